// File: hdl/mrsp_pkg.sv
// ----------------------------------------------------------------------------
// mrsp_pkg
// shared constants, types and the crc step for the modbus rtu reply parser
// ----------------------------------------------------------------------------
`default_nettype none

package mrsp_pkg;

  // number of holding registers the reply is expected to carry
  localparam int unsigned REGISTERS_READ = 8;

  localparam logic [7:0] BYTE_COUNT        = 8'(2 * REGISTERS_READ);
  localparam logic [7:0] FIRST_CAPTURE_POS = 8'd7;
  localparam logic [7:0] LAST_CAPTURE_POS  = 8'd18;
  localparam logic [7:0] FIRST_SLOT_POS    = 8'd8;
  // address, function, byte count, registers 0..7, two crc bytes
  localparam int unsigned MIN_FRAME_BYTES  = 21;
  localparam logic [7:0] SHORT_POS_LIMIT   = 8'(MIN_FRAME_BYTES - 1);
  localparam logic [7:0] POS_MAX           = 8'hFF;

  localparam int unsigned NUM_CAPTURED = 6;
  localparam int unsigned SLOT_W       = $clog2(NUM_CAPTURED);

  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  localparam logic [7:0] RESET_SLAVE_ADDRESS = 8'd1;
  localparam logic [7:0] RESET_FUNCTION_CODE = 8'd3;

  typedef enum logic [0:0] {
    REG_SLAVE_ADDRESS = 1'b0,
    REG_FUNCTION_CODE = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_SHORT = 2'd1,
    ST_CRC_BAD   = 2'd2,
    ST_HDR_BAD   = 2'd3
  } status_t;

  // one classified byte handed from the front to the back
  typedef struct packed {
    logic [7:0]        data;
    logic              last;
    logic              hdr_bad;
    logic              too_short;
    logic              cap_hi;
    logic              cap_lo;
    logic [SLOT_W-1:0] slot;
  } token_t;

  // reflected modbus crc-16, one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/mrsp_if.sv
// ----------------------------------------------------------------------------
// mrsp channel interfaces
// byte input channel and result output channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface mrsp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mrsp_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] temperature_value;
  logic [15:0]        temperature_unit;
  logic [7:0]         temperature_scale;
  logic signed [15:0] humidity_value;
  logic [15:0]        humidity_unit;
  logic [7:0]         humidity_scale;

  modport source (
    output valid, output status,
    output temperature_value, output temperature_unit, output temperature_scale,
    output humidity_value, output humidity_unit, output humidity_scale,
    input  ready
  );
  modport sink (
    input  valid, input status,
    input  temperature_value, input temperature_unit, input temperature_scale,
    input  humidity_value, input humidity_unit, input humidity_scale,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/modbus_rtu_sensor_reply_parser.sv
// ----------------------------------------------------------------------------
// modbus_rtu_sensor_reply_parser
// parses a modbus rtu read-holding-registers reply from a sensor, one byte
// per transaction, and reports temperature and humidity fields with a status
// ----------------------------------------------------------------------------
// result path: queue register, then result register
// throughput: one byte per cycle unless a final byte waits on an unread
//   result, set by the byte-wide combinational crc step in the back end;
//   the front stalls only while the two-entry queue is full
// reset: expected address 1, expected function 3, frame state cleared,
//   queue and result register empty; no clearing pass, ready right away
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_sensor_reply_parser
  import mrsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // byte input channel
  mrsp_rx_if.sink          rx,
  // result output channel
  mrsp_result_if.source    result,
  // apb-style configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0] expected_slave_address;
  logic [7:0] expected_function_code;
  logic       cfg_write;
  reg_index_t cfg_index;

  // front to queue
  logic   front_valid;
  token_t front_tok;
  logic   front_ready;

  // queue to back
  logic   back_valid;
  token_t back_tok;
  logic   back_ready;

  // ---------------------------------------------------------------------------
  // configuration registers, written in the access phase, word addressed
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_slave_address <= RESET_SLAVE_ADDRESS;
      expected_function_code <= RESET_FUNCTION_CODE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SLAVE_ADDRESS: expected_slave_address <= pwdata[7:0];
        REG_FUNCTION_CODE: expected_function_code <= pwdata[7:0];
        default:           expected_slave_address <= expected_slave_address;
      endcase
    end
  end

  // readback of the selected register
  always_comb begin
    case (cfg_index)
      REG_SLAVE_ADDRESS: prdata = {24'd0, expected_slave_address};
      REG_FUNCTION_CODE: prdata = {24'd0, expected_function_code};
      default:           prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // front: position tracking and header / capture classification
  // ---------------------------------------------------------------------------
  mrsp_front u_front (
    .clk                    (clk),
    .rst                    (rst),
    .rx                     (rx),
    .expected_slave_address (expected_slave_address),
    .expected_function_code (expected_function_code),
    .tok_valid              (front_valid),
    .tok                    (front_tok),
    .tok_ready              (front_ready)
  );

  // ---------------------------------------------------------------------------
  // short queue so front and back stall independently
  // ---------------------------------------------------------------------------
  mrsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_tok   (front_tok),
    .push_ready (front_ready),
    .pop_valid  (back_valid),
    .pop_tok    (back_tok),
    .pop_ready  (back_ready)
  );

  // ---------------------------------------------------------------------------
  // back: crc, register capture, status and result register
  // ---------------------------------------------------------------------------
  mrsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (back_valid),
    .tok       (back_tok),
    .tok_ready (back_ready),
    .result    (result)
  );

endmodule

`default_nettype wire

// File: hdl/mrsp_front.sv
// ----------------------------------------------------------------------------
// mrsp_front
// accepts reply bytes, tracks frame position and classifies each byte
// ----------------------------------------------------------------------------
`default_nettype none

module mrsp_front
  import mrsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  mrsp_rx_if.sink         rx,
  input  wire logic [7:0] expected_slave_address,
  input  wire logic [7:0] expected_function_code,
  output logic            tok_valid,
  output token_t          tok,
  input  wire logic       tok_ready
);

  logic [7:0] byte_position;
  logic [7:0] byte_position_next;
  logic [7:0] slot_offset;
  logic       in_capture;
  logic       accept;

  assign rx.ready  = tok_ready;
  assign tok_valid = rx.valid;
  assign accept    = rx.valid && tok_ready;

  assign in_capture  = (byte_position >= FIRST_CAPTURE_POS) &&
                       (byte_position <= LAST_CAPTURE_POS);
  assign slot_offset = byte_position - FIRST_SLOT_POS;

  always_comb begin
    tok.data      = rx.data_byte;
    tok.last      = rx.last_byte;
    tok.hdr_bad   = ((byte_position == 8'd0) && (rx.data_byte != expected_slave_address)) ||
                    ((byte_position == 8'd1) && (rx.data_byte != expected_function_code)) ||
                    ((byte_position == 8'd2) && (rx.data_byte != BYTE_COUNT));
    tok.too_short = byte_position < SHORT_POS_LIMIT;
    tok.cap_hi    = in_capture && byte_position[0];
    tok.cap_lo    = in_capture && !byte_position[0];
    tok.slot      = slot_offset[SLOT_W:1];
  end

  always_comb begin
    byte_position_next = byte_position;
    if (accept) begin
      if (rx.last_byte) begin
        byte_position_next = 8'd0;
      end else if (byte_position != POS_MAX) begin
        byte_position_next = byte_position + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 8'd0;
    end else begin
      byte_position <= byte_position_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/mrsp_queue.sv
// ----------------------------------------------------------------------------
// mrsp_queue
// two-entry token queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module mrsp_queue
  import mrsp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push_valid,
  input  wire token_t push_tok,
  output logic        push_ready,
  output logic        pop_valid,
  output token_t      pop_tok,
  input  wire logic   pop_ready
);

  token_t     entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_tok    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/mrsp_back.sv
// ----------------------------------------------------------------------------
// mrsp_back
// runs the crc, captures registers and builds the result at the final byte
// ----------------------------------------------------------------------------
`default_nettype none

module mrsp_back
  import mrsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        tok_valid,
  input  wire token_t      tok,
  output logic             tok_ready,
  mrsp_result_if.source    result
);

  logic [15:0] crc;
  logic [15:0] crc_next;
  logic        hdr_flag;
  logic [7:0]  high_byte_hold;
  logic [15:0] captured [NUM_CAPTURED];
  logic [15:0] captured_now [NUM_CAPTURED];
  logic        pop;
  logic        finish;
  status_t     status_next;

  assign tok_ready = !tok.last || !result.valid || result.ready;
  assign pop       = tok_valid && tok_ready;
  assign finish    = pop && tok.last;
  assign crc_next  = crc_feed(crc, tok.data);

  // register view including the byte being taken now
  always_comb begin
    for (int i = 0; i < NUM_CAPTURED; i++) begin
      captured_now[i] = captured[i];
      if (tok.cap_lo && (tok.slot == SLOT_W'(i))) begin
        captured_now[i] = {high_byte_hold, tok.data};
      end
    end
  end

  always_comb begin
    if (tok.too_short) begin
      status_next = ST_TOO_SHORT;
    end else if (crc_next != 16'd0) begin
      status_next = ST_CRC_BAD;
    end else if (hdr_flag || tok.hdr_bad) begin
      status_next = ST_HDR_BAD;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc      <= CRC_PRESET;
      hdr_flag <= 1'b0;
    end else if (pop) begin
      if (tok.last) begin
        crc      <= CRC_PRESET;
        hdr_flag <= 1'b0;
      end else begin
        crc      <= crc_next;
        hdr_flag <= hdr_flag || tok.hdr_bad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (tok.cap_hi) begin
        high_byte_hold <= tok.data;
      end
      for (int i = 0; i < NUM_CAPTURED; i++) begin
        captured[i] <= captured_now[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (finish) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.status <= status_next;
      if (status_next == ST_OK) begin
        result.temperature_value <= captured_now[0];
        result.temperature_unit  <= captured_now[1];
        result.temperature_scale <= 8'd0 - captured_now[2][7:0];
        result.humidity_value    <= captured_now[3];
        result.humidity_unit     <= captured_now[4];
        result.humidity_scale    <= 8'd0 - captured_now[5][7:0];
      end else begin
        result.temperature_value <= 16'sd0;
        result.temperature_unit  <= 16'd0;
        result.temperature_scale <= 8'd0;
        result.humidity_value    <= 16'sd0;
        result.humidity_unit     <= 16'd0;
        result.humidity_scale    <= 8'd0;
      end
    end
  end

endmodule

`default_nettype wire
